### rtl/psbs_pkg.sv
package psbs_pkg;

  // table geometry
  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // field widths
  localparam int MODE_W  = 2;
  localparam int AMT_W   = 48;
  localparam int PRICE_W = 32;
  localparam int TOTAL_W = 42;
  localparam int ITEMS_W = 11;

  // request modes
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [CNT_W-1:0]   count_t;

endpackage

### rtl/psbs_ram.sv
module psbs_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 42
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // one registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/prefix_sum_budget_search.sv
// Append, clear and unused-mode requests complete without leaving idle; busy stays low.
// A query runs a binary search over the n stored entries, one memory read per search step;
// a closing step ends the search, then the strobe follows.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Synchronous active-high reset empties the table; totals memory is not cleared.
module prefix_sum_budget_search
  import psbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  mode,
  input  logic [AMT_W-1:0]   amount,
  output logic               done,
  output logic [ITEMS_W-1:0] items_bought,
  output logic [AMT_W-1:0]   money_left
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic             state, state_next;
  count_t           entry_count, entry_count_next;
  total_t           running_total, running_total_next;
  count_t           lo, lo_next;
  count_t           hi, hi_next;
  total_t           best_total, best_total_next;
  logic [AMT_W-1:0] budget;
  logic             done_next;

  logic             accept;
  logic             ram_we;
  total_t           sum_total;
  total_t           rdata;
  count_t           mid;
  logic [ADDR_W-1:0] raddr;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);

  // new running total for an append
  assign sum_total = running_total + TOTAL_W'(amount[PRICE_W-1:0]);
  assign ram_we    = accept && (mode == MODE_APPEND) && (entry_count < CNT_W'(DEPTH));

  // request handling and search control: compare the entry read last cycle, narrow the interval
  always_comb begin
    state_next         = state;
    entry_count_next   = entry_count;
    running_total_next = running_total;
    lo_next            = lo;
    hi_next            = hi;
    best_total_next    = best_total;
    done_next          = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_APPEND: begin
              if (ram_we) begin
                running_total_next = sum_total;
                entry_count_next   = entry_count + 1'b1;
              end
            end
            MODE_QUERY: begin
              lo_next         = '0;
              hi_next         = entry_count;
              best_total_next = '0;
              state_next      = ST_SEARCH;
            end
            MODE_CLEAR: begin
              entry_count_next   = '0;
              running_total_next = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (lo < hi) begin
          if (AMT_W'(rdata) <= budget) begin
            lo_next         = mid + 1'b1;
            best_total_next = rdata;
          end else begin
            hi_next = mid;
          end
        end else begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // midpoint of the next interval (lo_next/hi_next), used as the address for the next read
  always_comb begin
    count_t nlo;
    count_t nhi;
    nlo   = lo_next;
    nhi   = hi_next;
    raddr = ADDR_W'(nlo + ((nhi - nlo) >> 1));
  end

  // midpoint of the entry now on the read port
  always_ff @(posedge clk) begin
    mid <= lo_next + ((hi_next - lo_next) >> 1);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_count   <= '0;
      running_total <= '0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      entry_count   <= entry_count_next;
      running_total <= running_total_next;
      done          <= done_next;
    end
  end

  // search registers and result
  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    best_total <= best_total_next;
    if (accept) begin
      budget <= amount;
    end
    if (done_next) begin
      items_bought <= ITEMS_W'(lo);
      money_left   <= budget - AMT_W'(best_total);
    end
  end

  psbs_ram #(
    .ADDR_W(ADDR_W),
    .DATA_W(TOTAL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count[ADDR_W-1:0]),
    .wdata (sum_total),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

### rtl/psbs_checker.sv
module psbs_checker
  import psbs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [MODE_W-1:0]  mode,
  input logic               done,
  input logic [ITEMS_W-1:0] items_bought
);

  // a result only appears once the search has ended
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // a query request starts a search
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_QUERY) |=> busy)
    else $error("query request did not start a search");

  // other requests finish at once and give no result
  a_other_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode != MODE_QUERY) |=> (!busy && !done))
    else $error("non-query request produced activity");

  // one strobe per query
  a_single_strobe: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

  // count never exceeds the table depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (items_bought <= ITEMS_W'(DEPTH)))
    else $error("item count beyond table depth");

endmodule

bind prefix_sum_budget_search psbs_checker u_psbs_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .mode         (mode),
  .done         (done),
  .items_bought (items_bought)
);
